### rtl/brm_pkg.sv
// Shared types, constants and the Booth digit decoder for the radix-4 multiplier.
package brm_pkg;

  localparam int IN_W             = 16;
  localparam int OUT_W            = 32;
  localparam int CNT_W            = 4;
  localparam int DEF_WIDTH        = 16;
  localparam int DIGITS_PER_STAGE = 2;

  typedef struct packed {
    logic signed [IN_W-1:0] multiplier_value;
    logic signed [IN_W-1:0] multiplicand_value;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] product_value;
    logic [CNT_W-1:0]        add_steps;
    logic [CNT_W-1:0]        sub_steps;
  } out_word_t;

  // running add/subtract digit counts carried down the pipe
  typedef struct packed {
    logic [CNT_W-1:0] adds;
    logic [CNT_W-1:0] subs;
  } count_t;

  // recoded digit: add or subtract, and whether the magnitude is 2M
  typedef struct packed {
    logic add;
    logic sub;
    logic dbl;
  } booth_sel_t;

  function automatic booth_sel_t booth_decode(input logic [2:0] trip);
    booth_sel_t sel;
    sel = '0;
    unique case (trip)
      3'b000, 3'b111: sel = '0;
      3'b001, 3'b010: sel.add = 1'b1;
      3'b011: begin
        sel.add = 1'b1;
        sel.dbl = 1'b1;
      end
      3'b100: begin
        sel.sub = 1'b1;
        sel.dbl = 1'b1;
      end
      3'b101, 3'b110: sel.sub = 1'b1;
    endcase
    return sel;
  endfunction

endpackage

### rtl/booth_radix4_multiplier_unit.sv
// Top level of the pipelined radix-4 Booth multiplier.
//
// Usage: src channel carries one operand word (multiplier, multiplicand, each
// taken as signed WIDTH bits from the low bits of its field); dst channel
// returns the signed product (low 32 bits), the count of add digits and the
// count of subtract digits, one result word per operand word, in order.
// Pipeline: an input register, ceil(ceil(WIDTH/2)/2) digit stages (two Booth
// digits summed per stage) and an output register, in that order.
// Throughput: one word per cycle while dst_ready is high; every stage has
// its own valid bit and accepts a new word whenever it is empty or its word
// moves on, so bubbles collapse and nothing is dropped or duplicated under
// back pressure.
// When dst_ready is held low the pipe fills and src_ready falls once every
// stage holds a word; the held result stays stable on dst_word.
// Reset (rst, synchronous) clears all valid bits; words in flight are dropped.
// Stage depth is one adder of 2*WIDTH (at least 32) bits with three inputs.
module booth_radix4_multiplier_unit #(
  parameter int WIDTH = brm_pkg::DEF_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  brm_pkg::in_word_t  src_word,
  output logic               dst_valid,
  input  logic               dst_ready,
  output brm_pkg::out_word_t dst_word
);
  import brm_pkg::*;

  localparam int NDIG = (WIDTH + 1) / 2;
  localparam int QW   = 2 * NDIG + 1;
  localparam int AW   = (2 * WIDTH > OUT_W) ? 2 * WIDTH : OUT_W;
  localparam int EW   = (WIDTH > IN_W) ? WIDTH : IN_W;
  localparam int NSTG = (NDIG + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;

  logic [QW-1:0] q_s   [NSTG+1];
  logic [AW-1:0] m_s   [NSTG+1];
  logic [AW-1:0] acc_s [NSTG+1];
  count_t        cnt_s [NSTG+1];
  logic          v_s   [NSTG+1];
  logic          r_s   [NSTG+1];

  // input register
  logic [EW-1:0]    q_raw;
  logic [EW-1:0]    m_raw;
  logic [WIDTH-1:0] q_op;
  logic [WIDTH-1:0] m_op;
  logic [QW-1:0]    q0;
  logic [AW-1:0]    m0;
  logic             v0;

  assign q_raw = EW'($unsigned(src_word.multiplier_value));
  assign m_raw = EW'($unsigned(src_word.multiplicand_value));
  assign q_op  = q_raw[WIDTH-1:0];
  assign m_op  = m_raw[WIDTH-1:0];

  assign src_ready = !v0 || r_s[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (src_ready) begin
      v0 <= src_valid;
    end
  end

  // multiplier gets the implicit zero below bit 0 and sign extension on top
  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      q0 <= {(QW-1)'($signed(q_op)), 1'b0};
      m0 <= AW'($signed(m_op));
    end
  end

  assign q_s[0]   = q0;
  assign m_s[0]   = m0;
  assign acc_s[0] = '0;
  assign cnt_s[0] = '0;
  assign v_s[0]   = v0;

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    brm_stage #(
      .WIDTH (WIDTH),
      .NDIG  (NDIG),
      .QW    (QW),
      .AW    (AW),
      .BASE  (k * DIGITS_PER_STAGE)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (v_s[k]),
      .up_ready (r_s[k]),
      .up_q     (q_s[k]),
      .up_m     (m_s[k]),
      .up_acc   (acc_s[k]),
      .up_cnt   (cnt_s[k]),
      .dn_valid (v_s[k+1]),
      .dn_ready (r_s[k+1]),
      .dn_q     (q_s[k+1]),
      .dn_m     (m_s[k+1]),
      .dn_acc   (acc_s[k+1]),
      .dn_cnt   (cnt_s[k+1])
    );
  end

  // output register
  assign r_s[NSTG] = !dst_valid || dst_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (r_s[NSTG]) begin
      dst_valid <= v_s[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (v_s[NSTG] && r_s[NSTG]) begin
      dst_word.product_value <= $signed(acc_s[NSTG][OUT_W-1:0]);
      dst_word.add_steps     <= cnt_s[NSTG].adds;
      dst_word.sub_steps     <= cnt_s[NSTG].subs;
    end
  end

`ifndef SYNTHESIS
  // input side only stalls when the whole pipe is full behind a held result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !src_ready |-> (dst_valid && !dst_ready))
    else $error("src_ready low without downstream back pressure");

  // no nonzero digit means a zero product (counts cannot wrap below 31 bits)
  a_zero_digits: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_word.add_steps == '0 && dst_word.sub_steps == '0 && WIDTH <= 30)
    |-> dst_word.product_value == '0)
    else $error("all-zero digits gave a nonzero product");

  // total digit count bounded by the recoded digit count
  a_digit_total: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && WIDTH <= 30)
    |-> ({1'b0, dst_word.add_steps} + {1'b0, dst_word.sub_steps}) <= 5'(NDIG))
    else $error("more add/sub digits than Booth digits");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("result word valid after reset");
`endif

endmodule

### rtl/brm_stage.sv
// One accumulation stage: adds the partial products of a group of Booth digits.
module brm_stage #(
  parameter int WIDTH = brm_pkg::DEF_WIDTH,
  parameter int NDIG  = (WIDTH + 1) / 2,
  parameter int QW    = 2 * NDIG + 1,
  parameter int AW    = (2 * WIDTH > brm_pkg::OUT_W) ? 2 * WIDTH : brm_pkg::OUT_W,
  parameter int BASE  = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  logic [QW-1:0]   up_q,
  input  logic [AW-1:0]   up_m,
  input  logic [AW-1:0]   up_acc,
  input  brm_pkg::count_t up_cnt,
  output logic            dn_valid,
  input  logic            dn_ready,
  output logic [QW-1:0]   dn_q,
  output logic [AW-1:0]   dn_m,
  output logic [AW-1:0]   dn_acc,
  output brm_pkg::count_t dn_cnt
);
  import brm_pkg::*;

  localparam int DPS = DIGITS_PER_STAGE;

  logic [AW-1:0]    pp    [DPS];
  logic [CNT_W-1:0] add_n [DPS];
  logic [CNT_W-1:0] sub_n [DPS];
  logic [AW-1:0]    acc_next;
  count_t           cnt_next;

  for (genvar j = 0; j < DPS; j++) begin : g_dig
    if (BASE + j < NDIG) begin : g_live
      booth_sel_t    sel;
      logic [AW-1:0] mag;
      logic [AW-1:0] shf;
      assign sel      = booth_decode(up_q[2*(BASE+j) +: 3]);
      assign mag      = sel.dbl ? (up_m << 1) : ((sel.add | sel.sub) ? up_m : '0);
      assign shf      = mag << (2 * (BASE + j));
      assign pp[j]    = sel.sub ? (~shf + AW'(1)) : shf;
      assign add_n[j] = CNT_W'(sel.add);
      assign sub_n[j] = CNT_W'(sel.sub);
    end else begin : g_pad
      assign pp[j]    = '0;
      assign add_n[j] = '0;
      assign sub_n[j] = '0;
    end
  end

  always_comb begin
    acc_next = up_acc;
    cnt_next = up_cnt;
    for (int j = 0; j < DPS; j++) begin
      acc_next      = acc_next + pp[j];
      cnt_next.adds = cnt_next.adds + add_n[j];
      cnt_next.subs = cnt_next.subs + sub_n[j];
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_q   <= up_q;
      dn_m   <= up_m;
      dn_acc <= acc_next;
      dn_cnt <= cnt_next;
    end
  end

endmodule
